/* rtl/pfla_pkg.sv */
// Shared constants, types and helper functions of the power-of-two free-list allocator.
package pfla_pkg;

  localparam int unsigned NUM_CLASSES     = 7;
  localparam int unsigned MIN_CLASS_BYTES = 64;
  localparam int unsigned PAGE_BYTES      = 16384;
  localparam int unsigned FIFO_DEPTH      = 256;
  localparam int unsigned ADDR_BITS       = 48;
  localparam int unsigned SIZE_W          = 15;

  localparam int unsigned CLS_W      = $clog2(NUM_CLASSES);
  localparam int unsigned IDX_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned MEM_AW     = CLS_W + IDX_W;
  localparam int unsigned MIN_SHIFT  = $clog2(MIN_CLASS_BYTES);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int unsigned TOP_CLASS  = NUM_CLASSES - 1;
  localparam int unsigned TOP_SHIFT  = MIN_SHIFT + TOP_CLASS;
  localparam int unsigned TOP_BYTES  = MIN_CLASS_BYTES << TOP_CLASS;
  localparam int unsigned N_REFILL   =
      (PAGE_BYTES > TOP_BYTES) ? (PAGE_BYTES + TOP_BYTES - 1) / TOP_BYTES - 1 : 0;
  localparam bit          REFILL_OK  = (N_REFILL <= FIFO_DEPTH);
  localparam int unsigned K_W        = $clog2(N_REFILL + 2);
  localparam int unsigned NEED_W     = $clog2(2 * NUM_CLASSES + 5);

  typedef logic [CLS_W-1:0]     cls_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SIZE_W-1:0]    size_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_MISALIGN  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_e;

  // Push and pop commands to the class lists.
  typedef struct packed {
    logic  push;
    cls_t  push_cls;
    addr_t push_addr;
    logic  pop;
    cls_t  pop_cls;
  } list_req_t;

  function automatic size_t cls_bytes(cls_t c);
    return size_t'(MIN_CLASS_BYTES) << c;
  endfunction

  function automatic addr_t cls_bytes_a(cls_t c);
    return addr_t'(MIN_CLASS_BYTES) << c;
  endfunction

endpackage

/* rtl/pfla_lists.sv */
// Per-class free-address FIFOs sharing one synchronous memory.
module pfla_lists (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfla_pkg::list_req_t req_i,
  output pfla_pkg::addr_t    rd_data_o,
  output pfla_pkg::cnt_t     count_o [pfla_pkg::NUM_CLASSES]
);
  import pfla_pkg::*;

  addr_t             mem_q [NUM_CLASSES*FIFO_DEPTH];
  addr_t             rd_q;
  logic [IDX_W-1:0]  head_q [NUM_CLASSES];
  logic [IDX_W-1:0]  tail_q [NUM_CLASSES];
  cnt_t              count_q [NUM_CLASSES];
  logic [MEM_AW-1:0] wr_idx;
  logic [MEM_AW-1:0] rd_idx;

  assign wr_idx = {req_i.push_cls, tail_q[req_i.push_cls]};
  assign rd_idx = {req_i.pop_cls, head_q[req_i.pop_cls]};

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      mem_q[wr_idx] <= req_i.push_addr;
    end
    if (req_i.pop) begin
      rd_q <= mem_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c]  <= '0;
        tail_q[c]  <= '0;
        count_q[c] <= '0;
      end
    end else begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (req_i.push && req_i.push_cls == cls_t'(c)) begin
          tail_q[c]  <= tail_q[c] + 1'b1;
          count_q[c] <= count_q[c] + 1'b1;
        end
        if (req_i.pop && req_i.pop_cls == cls_t'(c)) begin
          head_q[c]  <= head_q[c] + 1'b1;
          count_q[c] <= count_q[c] - 1'b1;
        end
      end
    end
  end

  assign rd_data_o = rd_q;
  assign count_o   = count_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.pop |-> count_q[req_i.pop_cls] != '0) else $error("pop from empty class");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> count_q[req_i.push_cls] < cnt_t'(FIFO_DEPTH))
    else $error("push into full class");
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.push && req_i.pop)) else $error("push and pop in one cycle");

endmodule

/* rtl/power_of_two_free_list_allocator_top.sv */
// Power-of-two free-list allocator: one request in, one result out, state in a shared memory.
//
// Each request is an allocate (tuser 0) or a free (tuser 1). Sizes round up to one of seven
// classes of 64 << c bytes; every class keeps its free addresses in a 256-entry FIFO held in
// one synchronous memory with one read or one write per cycle. An allocate that finds its
// class empty splits the nearest larger chunk, pushing one upper half per class walked down,
// and when even the top class is empty it takes the next page of the pool (pool_base +
// pages_used * 16384) and pushes the three remaining 4 KiB chunks. A free breaks the region
// into aligned chunks, at each step the largest aligned at the cursor that fits the rest, and
// pushes them only after checking that no class overflows; there is no coalescing. The block
// works on one request at a time: an allocate served from a list pops and then pushes one
// upper half per split; one that needs a page refill first pushes the rest of the page to
// the top class and then splits likewise; a free runs a count pass, a check, then a push
// pass; a free that would overflow a list stops after the check; the other errors go
// straight to the result, which waits while the previous one is still held for the
// receiver. The result sits in an output register, so the next request is taken while it
// waits. The memory needs no clearing pass after reset: an entry is only read once pushed.
module power_of_two_free_list_allocator_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // req_size[14:0], req_addr[62:15], zero pad
  input  logic [0:0]  s_axis_tuser,   // func[0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // grant_addr[47:0], class_bytes[62:48], zero pad
  output logic [2:0]  m_axis_tuser,   // status[2:0]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import pfla_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b00000001,
    S_POP_WAIT = 8'b00000010,
    S_PAGE     = 8'b00000100,
    S_SPLIT    = 8'b00001000,
    S_FCOUNT   = 8'b00010000,
    S_FCHECK   = 8'b00100000,
    S_FPUSH    = 8'b01000000,
    S_RESP     = 8'b10000000
  } state_e;

  localparam cls_t TOP = cls_t'(TOP_CLASS);

  state_e               state_q, state_d;
  cls_t                 id_q, id_d;
  cls_t                 cls_q, cls_d;
  addr_t                addr_q, addr_d;
  addr_t                cur_q, cur_d;
  size_t                rem_q, rem_d;
  logic [K_W-1:0]       k_q, k_d;
  logic [NEED_W-1:0]    need_q [NUM_CLASSES];
  logic [NEED_W-1:0]    need_d [NUM_CLASSES];
  logic [15:0]          pages_used_q, pages_used_d;
  addr_t                pool_base_q;
  logic [15:0]          pool_pages_q;
  addr_t                res_addr_q, res_addr_d;
  size_t                res_cb_q, res_cb_d;
  status_e              res_st_q, res_st_d;
  logic                 m_valid_q;
  addr_t                m_addr_q;
  size_t                m_cb_q;
  status_e              m_st_q;

  list_req_t            req;
  addr_t                rd_data;
  cnt_t                 count [NUM_CLASSES];

  logic                 in_acc;
  logic                 func;
  size_t                req_size;
  addr_t                req_addr;
  cls_t                 size_id;
  logic                 too_large;
  cls_t                 hit_cls;
  logic                 hit;
  cls_t                 pick;
  addr_t                pick_b;
  logic                 ovf;
  logic                 cfg_wr;

  assign func     = s_axis_tuser[0];
  assign req_size = s_axis_tdata[14:0];
  assign req_addr = s_axis_tdata[62:15];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Round the size up to a class; sizes above the top class are rejected.
  always_comb begin
    size_id   = TOP;
    too_large = (req_size > size_t'(TOP_BYTES));
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cls_bytes(cls_t'(c)) >= req_size) size_id = cls_t'(c);
    end
  end

  // Nearest non-empty class at or above the requested one.
  always_comb begin
    hit_cls = TOP;
    hit     = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (cls_t'(c) >= size_id && count[c] != '0) begin
        hit_cls = cls_t'(c);
        hit     = 1'b1;
      end
    end
  end

  // Largest chunk that is aligned at the cursor and fits the remainder.
  always_comb begin
    pick = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if ((cur_q & (cls_bytes_a(cls_t'(c)) - 1'b1)) == '0 &&
          rem_q >= cls_bytes(cls_t'(c))) begin
        pick = cls_t'(c);
      end
    end
  end
  assign pick_b = cls_bytes_a(pick);

  always_comb begin
    ovf = 1'b0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (({1'b0, count[c]} + (CNT_W+1)'(need_q[c])) > (CNT_W+1)'(FIFO_DEPTH)) ovf = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    id_d         = id_q;
    cls_d        = cls_q;
    addr_d       = addr_q;
    cur_d        = cur_q;
    rem_d        = rem_q;
    k_d          = k_q;
    need_d       = need_q;
    pages_used_d = pages_used_q;
    res_addr_d   = res_addr_q;
    res_cb_d     = res_cb_q;
    res_st_d     = res_st_q;
    req          = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          id_d       = size_id;
          res_addr_d = '0;
          res_cb_d   = cls_bytes(size_id);
          res_st_d   = ST_OK;
          state_d    = S_RESP;
          if (too_large) begin
            res_cb_d = '0;
            res_st_d = ST_TOO_LARGE;
          end else if (!func) begin
            if (hit) begin
              req.pop     = 1'b1;
              req.pop_cls = hit_cls;
              cls_d       = hit_cls;
              state_d     = S_POP_WAIT;
            end else if (pages_used_q >= pool_pages_q) begin
              res_st_d = ST_EXHAUSTED;
            end else if (!REFILL_OK) begin
              res_st_d = ST_OVERFLOW;
            end else begin
              addr_d       = pool_base_q + (addr_t'(pages_used_q) << PAGE_SHIFT);
              pages_used_d = pages_used_q + 1'b1;
              k_d          = K_W'(1);
              if (N_REFILL > 0) begin
                state_d = S_PAGE;
              end else if (size_id == TOP) begin
                res_addr_d = pool_base_q + (addr_t'(pages_used_q) << PAGE_SHIFT);
              end else begin
                cls_d   = TOP - 1'b1;
                state_d = S_SPLIT;
              end
            end
          end else if (req_addr[MIN_SHIFT-1:0] != '0) begin
            res_st_d = ST_MISALIGN;
          end else begin
            addr_d  = req_addr;
            cur_d   = req_addr;
            rem_d   = cls_bytes(size_id);
            for (int c = 0; c < NUM_CLASSES; c++) need_d[c] = '0;
            state_d = S_FCOUNT;
          end
        end
      end

      S_POP_WAIT: begin
        addr_d = rd_data;
        if (cls_q == id_q) begin
          res_addr_d = rd_data;
          state_d    = S_RESP;
        end else begin
          cls_d   = cls_q - 1'b1;
          state_d = S_SPLIT;
        end
      end

      S_PAGE: begin
        // Hand the rest of the fresh page to the top class.
        req.push      = 1'b1;
        req.push_cls  = TOP;
        req.push_addr = addr_q + (addr_t'(k_q) << TOP_SHIFT);
        k_d           = k_q + 1'b1;
        if (k_q == K_W'(N_REFILL)) begin
          if (id_q == TOP) begin
            res_addr_d = addr_q;
            state_d    = S_RESP;
          end else begin
            cls_d   = TOP - 1'b1;
            state_d = S_SPLIT;
          end
        end
      end

      S_SPLIT: begin
        // Push the upper half of each split, walking down to the requested class.
        req.push      = 1'b1;
        req.push_cls  = cls_q;
        req.push_addr = addr_q + cls_bytes_a(cls_q);
        if (cls_q == id_q) begin
          res_addr_d = addr_q;
          state_d    = S_RESP;
        end else begin
          cls_d = cls_q - 1'b1;
        end
      end

      S_FCOUNT: begin
        need_d[pick] = need_q[pick] + 1'b1;
        cur_d        = cur_q + pick_b;
        rem_d        = rem_q - cls_bytes(pick);
        if (rem_q == cls_bytes(pick)) state_d = S_FCHECK;
      end

      S_FCHECK: begin
        if (ovf) begin
          res_st_d = ST_OVERFLOW;
          state_d  = S_RESP;
        end else begin
          cur_d   = addr_q;
          rem_d   = cls_bytes(id_q);
          state_d = S_FPUSH;
        end
      end

      S_FPUSH: begin
        req.push      = 1'b1;
        req.push_cls  = pick;
        req.push_addr = cur_q;
        cur_d         = cur_q + pick_b;
        rem_d         = rem_q - cls_bytes(pick);
        if (rem_q == cls_bytes(pick)) state_d = S_RESP;
      end

      S_RESP: begin
        // Hold until the output register is free.
        if (!m_valid_q || m_axis_tready) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  pfla_lists u_lists (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd_data),
    .count_o   (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      pages_used_q <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      pages_used_q <= pages_used_d;
      if (state_q == S_RESP && state_d == S_IDLE) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    cls_q      <= cls_d;
    addr_q     <= addr_d;
    cur_q      <= cur_d;
    rem_q      <= rem_d;
    k_q        <= k_d;
    need_q     <= need_d;
    res_addr_q <= res_addr_d;
    res_cb_q   <= res_cb_d;
    res_st_q   <= res_st_d;
    if (state_q == S_RESP && state_d == S_IDLE) begin
      m_addr_q <= res_addr_q;
      m_cb_q   <= res_cb_q;
      m_st_q   <= res_st_q;
    end
  end

  // Configuration registers: pool_base at 0x0, pool_pages at 0x8.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      pool_pages_q <= '0;
    end else if (cfg_wr) begin
      if (!paddr[3]) pool_base_q  <= pwdata[ADDR_BITS-1:0];
      else           pool_pages_q <= pwdata[15:0];
    end
  end

  assign prdata = paddr[3] ? {48'd0, pool_pages_q} : 64'(pool_base_q);

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_cb_q, m_addr_q};
  assign m_axis_tuser  = m_st_q;

  a_acc_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE) else $error("accepted transaction left block idle");
  a_err_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_st_q != ST_OK |-> m_addr_q == '0) else $error("error result with address");
  a_split_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SPLIT |-> cls_q >= id_q) else $error("split walked below requested class");

endmodule
